@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/frnu_pkg.sv @@
// ----------------------------------------------------------------------------
// frnu_pkg
// types and codes for the file record name to utf-8 block
// ----------------------------------------------------------------------------
`default_nettype none

package frnu_pkg;

    localparam int ATTR_W    = 17;
    localparam int OUTCOME_W = 2;

    localparam logic [OUTCOME_W-1:0] OC_FOUND     = 2'd0;
    localparam logic [OUTCOME_W-1:0] OC_NOT_FOUND = 2'd1;
    localparam logic [OUTCOME_W-1:0] OC_TRUNCATED = 2'd2;

    typedef struct packed {
        logic [7:0] record_byte;
        logic       end_of_record;
    } in_beat_t;

    typedef struct packed {
        logic [7:0]           utf8_byte;
        logic                 byte_valid;
        logic                 name_end;
        logic [OUTCOME_W-1:0] outcome;
    } out_beat_t;

    // one queue entry: a utf-16 unit to encode, or a bare end marker
    typedef struct packed {
        logic [15:0]          unit;
        logic                 is_unit;
        logic                 name_end;
        logic [OUTCOME_W-1:0] outcome;
    } cmd_t;

endpackage

`default_nettype wire

@@ design/frnu_front.sv @@
// ----------------------------------------------------------------------------
// frnu_front
// record parser: walks the attribute chain and queues name units
// ----------------------------------------------------------------------------
`default_nettype none

module frnu_front #(
    parameter int RECORD_BYTES = 1024
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire frnu_pkg::in_beat_t item,
    input  wire logic              accept,
    output logic                   cmd_push,
    output frnu_pkg::cmd_t         cmd
);

    localparam int POS_W  = $clog2(RECORD_BYTES + 1);
    localparam int ATTR_W = frnu_pkg::ATTR_W;

    localparam logic [POS_W-1:0]  POS_LIMIT    = POS_W'(RECORD_BYTES);
    localparam logic [POS_W-1:0]  POS_LAST     = POS_W'(RECORD_BYTES - 1);
    localparam logic [ATTR_W-1:0] FIRST_OFS_LO = ATTR_W'(20);
    localparam logic [ATTR_W-1:0] FIRST_OFS_HI = ATTR_W'(21);
    localparam logic [15:0]       MIN_FIRST    = 16'h0016;
    localparam logic [31:0]       END_TYPE     = 32'hFFFF_FFFF;
    localparam logic [31:0]       NAME_TYPE    = 32'h0000_0030;
    localparam logic [31:0]       MIN_ATTR_LEN = 32'd22;
    localparam logic [ATTR_W-1:0] NAME_LEN_OFS = ATTR_W'(64);
    localparam logic [32:0]       REC_END_W    = 33'(RECORD_BYTES);
    localparam logic [ATTR_W-1:0] REC_END      = ATTR_W'(RECORD_BYTES);

    typedef enum logic [6:0] {
        PH_SEEK = 7'b0000001,
        PH_HDR  = 7'b0000010,
        PH_NLEN = 7'b0000100,
        PH_NPAD = 7'b0001000,
        PH_ULO  = 7'b0010000,
        PH_UHI  = 7'b0100000,
        PH_DONE = 7'b1000000
    } phase_t;

    phase_t            phase_reg, phase_next, phase_cur;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [ATTR_W-1:0] start_reg, start_next;
    logic [31:0]       type_reg, type_next;
    logic [31:0]       length_reg, length_next;
    logic [7:0]        resident_reg, resident_next;
    logic [7:0]        content_lo_reg, content_lo_next;
    logic [7:0]        units_reg, units_next;
    logic [7:0]        low_reg, low_next;

    logic [7:0]        b;
    logic              last;
    logic              emit;
    frnu_pkg::cmd_t    cmd_next;
    logic [ATTR_W-1:0] pos_ext;
    logic [ATTR_W-1:0] rel;
    logic              in_hdr;
    logic [15:0]       first_ofs;
    logic [ATTR_W-1:0] name_start;
    logic [32:0]       attr_sum;
    logic [7:0]        units_dec;

    assign b    = item.record_byte;
    assign last = item.end_of_record || (pos_reg == POS_LAST);

    always_comb
    begin
        phase_cur       = (pos_reg == POS_LIMIT) ? PH_DONE : phase_reg;
        phase_next      = phase_cur;
        pos_next        = pos_reg;
        start_next      = start_reg;
        type_next       = type_reg;
        length_next     = length_reg;
        resident_next   = resident_reg;
        content_lo_next = content_lo_reg;
        units_next      = units_reg;
        low_next        = low_reg;
        emit            = 1'b0;
        cmd_next        = '0;
        cmd_next.outcome = frnu_pkg::OC_FOUND;

        pos_ext    = ATTR_W'(pos_reg);
        rel        = pos_ext - start_reg;
        in_hdr     = (pos_ext >= start_reg);
        first_ofs  = {b, start_reg[7:0]};
        name_start = start_reg + ATTR_W'({b, content_lo_reg}) + NAME_LEN_OFS;
        attr_sum   = 33'(start_reg) + 33'(length_reg);
        units_dec  = units_reg - 8'd1;

        unique case (phase_cur)
            PH_SEEK:
            begin
                if (pos_ext == FIRST_OFS_LO)
                begin
                    start_next = ATTR_W'(b);
                end
                else if (pos_ext == FIRST_OFS_HI)
                begin
                    start_next = ATTR_W'(first_ofs);
                    if (first_ofs < MIN_FIRST)
                    begin
                        emit             = 1'b1;
                        cmd_next.name_end = 1'b1;
                        cmd_next.outcome = frnu_pkg::OC_NOT_FOUND;
                        phase_next       = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_HDR;
                    end
                end
            end
            PH_HDR:
            begin
                if (in_hdr && (rel[ATTR_W-1:5] == '0))
                begin
                    case (rel[4:0]) inside
                        5'd0, 5'd1, 5'd2:
                        begin
                            type_next[{rel[1:0], 3'b000} +: 8] = b;
                        end
                        5'd3:
                        begin
                            type_next[31:24] = b;
                            if ({b, type_reg[23:0]} == END_TYPE)
                            begin
                                emit             = 1'b1;
                                cmd_next.name_end = 1'b1;
                                cmd_next.outcome = frnu_pkg::OC_NOT_FOUND;
                                phase_next       = PH_DONE;
                            end
                        end
                        5'd4, 5'd5, 5'd6, 5'd7:
                        begin
                            length_next[{rel[1:0], 3'b000} +: 8] = b;
                        end
                        5'd8:
                        begin
                            resident_next = b;
                        end
                        5'd20:
                        begin
                            content_lo_next = b;
                        end
                        5'd21:
                        begin
                            if ((type_reg == NAME_TYPE) && (resident_reg == 8'd0))
                            begin
                                start_next = name_start;
                                phase_next = PH_NLEN;
                            end
                            else if (length_reg < MIN_ATTR_LEN)
                            begin
                                emit             = 1'b1;
                                cmd_next.name_end = 1'b1;
                                cmd_next.outcome = frnu_pkg::OC_NOT_FOUND;
                                phase_next       = PH_DONE;
                            end
                            else if (attr_sum > REC_END_W)
                            begin
                                start_next = REC_END;
                            end
                            else
                            begin
                                start_next = attr_sum[ATTR_W-1:0];
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            PH_NLEN:
            begin
                if (pos_ext == start_reg)
                begin
                    units_next = b;
                    if (b == 8'd0)
                    begin
                        emit             = 1'b1;
                        cmd_next.name_end = 1'b1;
                        cmd_next.outcome = frnu_pkg::OC_FOUND;
                        phase_next       = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_NPAD;
                    end
                end
            end
            PH_NPAD:
            begin
                phase_next = PH_ULO;
            end
            PH_ULO:
            begin
                low_next   = b;
                phase_next = PH_UHI;
            end
            PH_UHI:
            begin
                emit             = 1'b1;
                cmd_next.is_unit = 1'b1;
                cmd_next.unit    = {b, low_reg};
                units_next       = units_dec;
                if (units_dec == 8'd0)
                begin
                    cmd_next.name_end = 1'b1;
                    cmd_next.outcome = frnu_pkg::OC_FOUND;
                    phase_next       = PH_DONE;
                end
                else
                begin
                    phase_next = PH_ULO;
                end
            end
            PH_DONE:
            begin
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        // record end closes whatever is still open
        if (last && (phase_next != PH_DONE))
        begin
            emit              = 1'b1;
            cmd_next.name_end = 1'b1;
            if ((phase_next == PH_SEEK) || (phase_next == PH_HDR))
            begin
                cmd_next.outcome = frnu_pkg::OC_NOT_FOUND;
            end
            else
            begin
                cmd_next.outcome = frnu_pkg::OC_TRUNCATED;
            end
            phase_next = PH_DONE;
        end

        if (item.end_of_record)
        begin
            pos_next   = '0;
            phase_next = PH_SEEK;
        end
        else if (pos_reg != POS_LIMIT)
        begin
            pos_next = pos_reg + POS_W'(1);
        end
    end

    assign cmd_push = accept && emit;
    assign cmd      = cmd_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEEK;
            pos_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            start_reg      <= start_next;
            type_reg       <= type_next;
            length_reg     <= length_next;
            resident_reg   <= resident_next;
            content_lo_reg <= content_lo_next;
            units_reg      <= units_next;
            low_reg        <= low_next;
        end
    end

endmodule

`default_nettype wire

@@ design/frnu_cmdq.sv @@
// ----------------------------------------------------------------------------
// frnu_cmdq
// short queue of parsed units between the parser and the encoder
// ----------------------------------------------------------------------------
`default_nettype none

module frnu_cmdq #(
    parameter int DEPTH = 4
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire frnu_pkg::cmd_t wr_data,
    input  wire logic           rd_en,
    output frnu_pkg::cmd_t      rd_data,
    output logic                full,
    output logic                empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    frnu_pkg::cmd_t slots_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign rd_data = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slots_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

@@ design/frnu_back.sv @@
// ----------------------------------------------------------------------------
// frnu_back
// utf-8 encoder: one beat per cycle while not stalled, from the queue head
// ----------------------------------------------------------------------------
`default_nettype none

module frnu_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire frnu_pkg::cmd_t head,
    input  wire logic           head_valid,
    output logic                head_pop,
    output frnu_pkg::out_beat_t result,
    output logic                empty,
    input  wire logic           pop
);

    localparam logic [15:0] TWO_BYTE_MIN   = 16'h0080;
    localparam logic [15:0] THREE_BYTE_MIN = 16'h0800;
    localparam logic [7:0]  LEAD2          = 8'hC0;
    localparam logic [7:0]  LEAD3          = 8'hE0;
    localparam logic [7:0]  CONT           = 8'h80;

    logic [1:0]          idx_reg, idx_next;
    logic                ovalid_reg, ovalid_next;
    frnu_pkg::out_beat_t obeat_reg, obeat_next;

    logic [1:0] last_idx;
    logic       is_last;
    logic       advance;
    logic [7:0] enc_byte;
    logic [15:0] u;

    assign u = head.unit;

    always_comb
    begin
        if (!head.is_unit || (u < TWO_BYTE_MIN))
        begin
            last_idx = 2'd0;
        end
        else if (u < THREE_BYTE_MIN)
        begin
            last_idx = 2'd1;
        end
        else
        begin
            last_idx = 2'd2;
        end

        enc_byte = CONT | {2'b00, u[5:0]};
        case (last_idx)
            2'd0:
            begin
                enc_byte = u[7:0];
            end
            2'd1:
            begin
                if (idx_reg == 2'd0)
                begin
                    enc_byte = LEAD2 | {3'b000, u[10:6]};
                end
            end
            default:
            begin
                if (idx_reg == 2'd0)
                begin
                    enc_byte = LEAD3 | {4'b0000, u[15:12]};
                end
                else if (idx_reg == 2'd1)
                begin
                    enc_byte = CONT | {2'b00, u[11:6]};
                end
            end
        endcase
    end

    assign is_last  = (idx_reg == last_idx);
    assign advance  = head_valid && (!ovalid_reg || pop);
    assign head_pop = advance && is_last;

    always_comb
    begin
        obeat_next            = obeat_reg;
        idx_next              = idx_reg;
        ovalid_next           = ovalid_reg && !pop;
        if (advance)
        begin
            obeat_next.utf8_byte  = head.is_unit ? enc_byte : 8'd0;
            obeat_next.byte_valid = head.is_unit;
            obeat_next.name_end   = is_last && head.name_end;
            obeat_next.outcome    = is_last ? head.outcome : frnu_pkg::OC_FOUND;
            idx_next              = is_last ? 2'd0 : idx_reg + 2'd1;
            ovalid_next           = 1'b1;
        end
    end

    assign result = obeat_reg;
    assign empty  = !ovalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= 2'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        obeat_reg <= obeat_next;
    end

endmodule

`default_nettype wire

@@ design/file_record_name_to_utf8.sv @@
// ----------------------------------------------------------------------------
// file_record_name_to_utf8
// streams a file record in and the utf-8 form of its name attribute out
// ----------------------------------------------------------------------------
// usage
//   input side is a queue write: item carries one record byte and the
//   end-of-record mark; a beat is taken when push is high and full is low
//   result side is a queue read: while empty is low the oldest result beat
//   sits on result, and it leaves when pop is high
//   the parser takes one byte per cycle as long as the unit queue has room;
//   each name unit needs two record bytes and gives one to three beats
//   the first beat of a unit is written to the unit queue when its high byte
//   is taken, and then from the queue head into the output register
//   the encoder sends one beat per cycle while a unit is queued and the
//   output register is free or popped, one beat per byte of the utf-8 form;
//   the parser meanwhile takes record bytes as long as the queue has room
//   the last beat of each record has name_end set and carries the outcome
//   reset clears the parser position, the unit queue and the output valid flag
//   when pop stays low the output register holds, the queue fills and full
//   rises until the receiver drains it
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module file_record_name_to_utf8 #(
    parameter int RECORD_BYTES = 1024
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire frnu_pkg::in_beat_t  item,
    input  wire logic                push,
    output logic                     full,
    output frnu_pkg::out_beat_t      result,
    output logic                     empty,
    input  wire logic                pop
);

    localparam int CMDQ_DEPTH = 4;

    logic           accept;
    logic           cmd_push;
    frnu_pkg::cmd_t cmd;
    frnu_pkg::cmd_t head;
    logic           head_pop;
    logic           cmdq_full;
    logic           cmdq_empty;

    assign full   = cmdq_full;
    assign accept = push && !cmdq_full;

    frnu_front #(
        .RECORD_BYTES (RECORD_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .accept   (accept),
        .cmd_push (cmd_push),
        .cmd      (cmd)
    );

    frnu_cmdq #(
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd),
        .rd_en   (head_pop),
        .rd_data (head),
        .full    (cmdq_full),
        .empty   (cmdq_empty)
    );

    frnu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (!cmdq_empty),
        .head_pop   (head_pop),
        .result     (result),
        .empty      (empty),
        .pop        (pop)
    );

    `ASSERT_IMP(a_marker_ends, clk, rst_n, !empty && !result.byte_valid, result.name_end, "beat without a name byte is not a record end")
    `ASSERT_IMP(a_outcome_at_end, clk, rst_n, !empty && (result.outcome != frnu_pkg::OC_FOUND), result.name_end, "outcome set on a beat that does not end the record")
    `ASSERT_IMP(a_no_overrun, clk, rst_n, cmd_push, !cmdq_full, "unit queue written while full")
    `ASSERT_NEXT(a_no_phantom, clk, rst_n, cmdq_empty && empty, empty, "result beat appeared with nothing queued")

endmodule

`default_nettype wire
